/* rtl/stle_pkg.sv */
// ----------------------------------------------------------------------------
// Scancode line editor package
// Event codes, event record, scancode constants and the two keymap ROMs.
// ----------------------------------------------------------------------------
package stle_pkg;

    typedef enum logic [1:0] {
        EV_APPEND = 2'd0,
        EV_ERASE  = 2'd1,
        EV_SUBMIT = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic        valid;
        t_event_kind kind;
        logic [6:0]  char_code;
        logic [7:0]  pos;
    } t_event;

    localparam logic [7:0] SC_PREFIX      = 8'hE0;
    localparam logic [6:0] SC_LEFT_SHIFT  = 7'h2A;
    localparam logic [6:0] SC_RIGHT_SHIFT = 7'h36;
    localparam logic [6:0] SC_CAPS_LOCK   = 7'h3A;
    localparam logic [7:0] KEY_COUNT      = 8'd58;

    localparam logic [6:0] CH_BACKSPACE   = 7'h08;
    localparam logic [6:0] CH_NEWLINE     = 7'h0A;
    localparam logic [6:0] CH_FIRST_PRINT = 7'h20;
    localparam logic [6:0] CH_LAST_PRINT  = 7'h7E;
    localparam logic [6:0] CH_CASE_STEP   = 7'h20;

    function automatic logic [6:0] plain_map(input logic [5:0] idx);
        logic [6:0] c;
        unique case (idx)
            6'd1:  c = 7'h1B;
            6'd2:  c = 7'h31;
            6'd3:  c = 7'h32;
            6'd4:  c = 7'h33;
            6'd5:  c = 7'h34;
            6'd6:  c = 7'h35;
            6'd7:  c = 7'h36;
            6'd8:  c = 7'h37;
            6'd9:  c = 7'h38;
            6'd10: c = 7'h39;
            6'd11: c = 7'h30;
            6'd12: c = 7'h2D;
            6'd13: c = 7'h3D;
            6'd14: c = 7'h08;
            6'd15: c = 7'h09;
            6'd16: c = 7'h71;
            6'd17: c = 7'h77;
            6'd18: c = 7'h65;
            6'd19: c = 7'h72;
            6'd20: c = 7'h74;
            6'd21: c = 7'h79;
            6'd22: c = 7'h75;
            6'd23: c = 7'h69;
            6'd24: c = 7'h6F;
            6'd25: c = 7'h70;
            6'd26: c = 7'h5B;
            6'd27: c = 7'h5D;
            6'd28: c = 7'h0A;
            6'd30: c = 7'h61;
            6'd31: c = 7'h73;
            6'd32: c = 7'h64;
            6'd33: c = 7'h66;
            6'd34: c = 7'h67;
            6'd35: c = 7'h68;
            6'd36: c = 7'h6A;
            6'd37: c = 7'h6B;
            6'd38: c = 7'h6C;
            6'd39: c = 7'h3B;
            6'd40: c = 7'h27;
            6'd41: c = 7'h60;
            6'd43: c = 7'h5C;
            6'd44: c = 7'h7A;
            6'd45: c = 7'h78;
            6'd46: c = 7'h63;
            6'd47: c = 7'h76;
            6'd48: c = 7'h62;
            6'd49: c = 7'h6E;
            6'd50: c = 7'h6D;
            6'd51: c = 7'h2C;
            6'd52: c = 7'h2E;
            6'd53: c = 7'h2F;
            6'd55: c = 7'h2A;
            6'd57: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shift_map(input logic [5:0] idx);
        logic [6:0] c;
        unique case (idx)
            6'd1:  c = 7'h1B;
            6'd2:  c = 7'h21;
            6'd3:  c = 7'h40;
            6'd4:  c = 7'h23;
            6'd5:  c = 7'h24;
            6'd6:  c = 7'h25;
            6'd7:  c = 7'h5E;
            6'd8:  c = 7'h26;
            6'd9:  c = 7'h2A;
            6'd10: c = 7'h28;
            6'd11: c = 7'h29;
            6'd12: c = 7'h5F;
            6'd13: c = 7'h2B;
            6'd14: c = 7'h08;
            6'd15: c = 7'h09;
            6'd16: c = 7'h51;
            6'd17: c = 7'h57;
            6'd18: c = 7'h45;
            6'd19: c = 7'h52;
            6'd20: c = 7'h54;
            6'd21: c = 7'h59;
            6'd22: c = 7'h55;
            6'd23: c = 7'h49;
            6'd24: c = 7'h4F;
            6'd25: c = 7'h50;
            6'd26: c = 7'h7B;
            6'd27: c = 7'h7D;
            6'd28: c = 7'h0A;
            6'd30: c = 7'h41;
            6'd31: c = 7'h53;
            6'd32: c = 7'h44;
            6'd33: c = 7'h46;
            6'd34: c = 7'h47;
            6'd35: c = 7'h48;
            6'd36: c = 7'h4A;
            6'd37: c = 7'h4B;
            6'd38: c = 7'h4C;
            6'd39: c = 7'h3A;
            6'd40: c = 7'h22;
            6'd41: c = 7'h7E;
            6'd43: c = 7'h7C;
            6'd44: c = 7'h5A;
            6'd45: c = 7'h58;
            6'd46: c = 7'h43;
            6'd47: c = 7'h56;
            6'd48: c = 7'h42;
            6'd49: c = 7'h4E;
            6'd50: c = 7'h4D;
            6'd51: c = 7'h3C;
            6'd52: c = 7'h3E;
            6'd53: c = 7'h3F;
            6'd55: c = 7'h2A;
            6'd57: c = 7'h20;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/stle_scan_if.sv */
// ----------------------------------------------------------------------------
// Scancode channel
// Valid/ready channel carrying one raw Set 1 scancode byte per beat.
// ----------------------------------------------------------------------------
interface stle_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

/* rtl/stle_event_if.sv */
// ----------------------------------------------------------------------------
// Line event channel
// Valid/ready channel carrying one line-editing event per beat.
// ----------------------------------------------------------------------------
interface stle_event_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [6:0] char_code;
    logic [7:0] line_position;

    modport source (output valid, output event_kind, output char_code,
                    output line_position, input ready);
    modport sink   (input valid, input event_kind, input char_code,
                    input line_position, output ready);
endinterface

/* rtl/scancode_to_line_editor.sv */
// ----------------------------------------------------------------------------
// Scancode to line editor
// Turns PS/2 Set 1 scancode bytes into append, erase and submit events.
//
// i_scan takes one scancode byte per beat; o_event gives at most one event
// per byte: event_kind, char_code and line_position. Bytes that only change
// shift, caps lock or prefix state, and dropped keys, give no event.
// A byte is registered on acceptance, decoded from that register against
// the flags and line length once the output register can take the result,
// and its event is registered for output. One byte per cycle
// is taken while the output register can drain; the decode stage and the
// single output register set that rate. When o_event is stalled, the event
// holds and the held byte waits, and i_scan.ready falls once both stages
// are full. A synchronous reset clears the flags, the line length and both
// stages, and gives no event. LINE_CAPACITY bounds the line to
// LINE_CAPACITY - 1 characters, and never more than 255.
// ----------------------------------------------------------------------------
module scancode_to_line_editor #(
    parameter int LINE_CAPACITY = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    stle_scan_if.sink    i_scan,
    stle_event_if.source o_event
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_code;
    logic             r_out_valid, n_out_valid;
    stle_pkg::t_event r_out;
    stle_pkg::t_event step_event;
    logic             advance;
    logic             in_take;

    assign advance = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_scan.ready = !r_in_valid || advance;
    assign in_take = i_scan.valid && i_scan.ready;

    stle_editor #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_editor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_scan_code (r_in_code),
        .o_event     (step_event)
    );

    always_comb begin
        n_in_valid = in_take ? 1'b1 : (r_in_valid && !advance);
        if (advance) begin
            n_out_valid = step_event.valid;
        end else begin
            n_out_valid = r_out_valid && !o_event.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_code <= i_scan.scan_code;
        end
        if (advance && step_event.valid) begin
            r_out <= step_event;
        end
    end

    assign o_event.valid         = r_out_valid;
    assign o_event.event_kind    = r_out.kind;
    assign o_event.char_code     = r_out.char_code;
    assign o_event.line_position = r_out.pos;

endmodule

/* rtl/stle_keymap.sv */
// ----------------------------------------------------------------------------
// Keymap lookup
// Maps a make code to ASCII through the plain or shifted ROM and applies
// the letter case given by caps lock XOR shift. Zero means no character.
// ----------------------------------------------------------------------------
module stle_keymap (
    input  logic [7:0] i_scan_code,
    input  logic       i_shift,
    input  logic       i_caps,
    output logic [6:0] o_char
);

    logic [6:0] rom_char;
    logic       upper;

    always_comb begin
        if (i_scan_code < stle_pkg::KEY_COUNT) begin
            rom_char = i_shift ? stle_pkg::shift_map(i_scan_code[5:0])
                               : stle_pkg::plain_map(i_scan_code[5:0]);
        end else begin
            rom_char = 7'h00;
        end
    end

    assign upper = i_caps ^ i_shift;

    always_comb begin
        o_char = rom_char;
        if (rom_char >= 7'h61 && rom_char <= 7'h7A) begin
            if (upper) begin
                o_char = rom_char - stle_pkg::CH_CASE_STEP;
            end
        end else if (rom_char >= 7'h41 && rom_char <= 7'h5A) begin
            if (!upper) begin
                o_char = rom_char + stle_pkg::CH_CASE_STEP;
            end
        end
    end

endmodule

/* rtl/stle_editor.sv */
// ----------------------------------------------------------------------------
// Line editor core
// Holds the shift, caps lock and prefix flags and the line length, and turns
// one scancode into at most one append, erase or submit event.
// ----------------------------------------------------------------------------
module stle_editor #(
    parameter int LINE_CAPACITY = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_scan_code,
    output stle_pkg::t_event o_event
);

    localparam int LenLimitInt = (LINE_CAPACITY - 1 > 255) ? 255 : LINE_CAPACITY - 1;
    localparam logic [7:0] LenLimit = 8'(LenLimitInt);

    logic       r_shift, n_shift;
    logic       r_caps, n_caps;
    logic       r_prefix, n_prefix;
    logic [7:0] r_len, n_len;
    logic [6:0] key_char;

    stle_keymap u_keymap (
        .i_scan_code (i_scan_code),
        .i_shift     (r_shift),
        .i_caps      (r_caps),
        .o_char      (key_char)
    );

    always_comb begin
        n_shift   = r_shift;
        n_caps    = r_caps;
        n_prefix  = r_prefix;
        n_len     = r_len;
        o_event   = '0;
        o_event.kind      = stle_pkg::EV_APPEND;
        o_event.char_code = key_char;
        o_event.pos       = r_len;
        if (i_step) begin
            if (i_scan_code == stle_pkg::SC_PREFIX) begin
                n_prefix = 1'b1;
            end else if (r_prefix) begin
                n_prefix = 1'b0;
            end else if (i_scan_code[7]) begin
                if (i_scan_code[6:0] == stle_pkg::SC_LEFT_SHIFT ||
                    i_scan_code[6:0] == stle_pkg::SC_RIGHT_SHIFT) begin
                    n_shift = 1'b0;
                end
            end else if (i_scan_code[6:0] == stle_pkg::SC_LEFT_SHIFT ||
                         i_scan_code[6:0] == stle_pkg::SC_RIGHT_SHIFT) begin
                n_shift = 1'b1;
            end else if (i_scan_code[6:0] == stle_pkg::SC_CAPS_LOCK) begin
                n_caps = ~r_caps;
            end else if (key_char == stle_pkg::CH_NEWLINE) begin
                o_event.valid = 1'b1;
                o_event.kind  = stle_pkg::EV_SUBMIT;
                n_len         = 8'd0;
            end else if (key_char == stle_pkg::CH_BACKSPACE) begin
                if (r_len != 8'd0) begin
                    n_len         = r_len - 8'd1;
                    o_event.valid = 1'b1;
                    o_event.kind  = stle_pkg::EV_ERASE;
                    o_event.pos   = r_len - 8'd1;
                end
            end else if (key_char >= stle_pkg::CH_FIRST_PRINT &&
                         key_char <= stle_pkg::CH_LAST_PRINT) begin
                if (r_len < LenLimit) begin
                    n_len         = r_len + 8'd1;
                    o_event.valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
            r_prefix <= 1'b0;
            r_len    <= 8'd0;
        end else begin
            r_shift  <= n_shift;
            r_caps   <= n_caps;
            r_prefix <= n_prefix;
            r_len    <= n_len;
        end
    end

    a_append_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid && o_event.kind == stle_pkg::EV_APPEND |-> r_len < LenLimit)
        else $error("append issued with the line full");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid && o_event.kind == stle_pkg::EV_APPEND
        |=> r_len == $past(r_len) + 8'd1)
        else $error("line length did not advance after append");

    a_submit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid && o_event.kind == stle_pkg::EV_SUBMIT |=> r_len == 8'd0)
        else $error("line length not cleared after submit");

    a_erase_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid && o_event.kind == stle_pkg::EV_ERASE |-> r_len != 8'd0)
        else $error("erase issued on an empty line");

    a_prefix_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_prefix |-> !o_event.valid)
        else $error("event issued for a byte after the extension prefix");

endmodule

/* tb/sv/stle_line_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line event checker
// Watches the scancode and event channels of the line editor. It decodes each
// accepted scancode beat against its own shift, caps lock, prefix and length
// state, queues the event that should follow, and compares every event beat
// with the oldest queued one. It hands the mismatch count and the number of
// events still awaited to the testbench top.
// ----------------------------------------------------------------------------
module stle_line_checker #(
    parameter int LINE_CAPACITY = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_scan_valid,
    input  logic       i_scan_ready,
    input  logic [7:0] i_scan_code,
    input  logic       i_event_valid,
    input  logic       i_event_ready,
    input  logic [1:0] i_event_kind,
    input  logic [6:0] i_char_code,
    input  logic [7:0] i_line_position,
    output int         o_mismatches,
    output int         o_awaiting
);
    import stle_pkg::*;

    localparam int LEN_LIMIT = (LINE_CAPACITY - 1 > 255) ? 255 : LINE_CAPACITY - 1;
    localparam int REPORT_LIMIT = 10;

    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_Z = 7'h7A;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_UPPER_Z = 7'h5A;

    typedef struct {
        t_event_kind kind;
        logic [6:0]  ch;
        logic [7:0]  pos;
    } t_line_event;

    logic [6:0] plain_keys [0:57] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    logic [6:0] shift_keys [0:57] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    logic        shift_down;
    logic        caps_on;
    logic        prefix_seen;
    int          char_count;
    t_line_event pending_events [$];
    int          mismatch_count;

    function automatic bit decode_scancode(input logic [7:0] code, output t_line_event ev);
        logic [6:0] ch;
        logic       upper;
        ev.kind = EV_APPEND;
        ev.ch   = '0;
        ev.pos  = '0;
        if (code == SC_PREFIX) begin
            prefix_seen = 1'b1;
            return 1'b0;
        end
        if (prefix_seen) begin
            prefix_seen = 1'b0;
            return 1'b0;
        end
        if (code[7]) begin
            if (code[6:0] == SC_LEFT_SHIFT || code[6:0] == SC_RIGHT_SHIFT)
                shift_down = 1'b0;
            return 1'b0;
        end
        if (code[6:0] == SC_LEFT_SHIFT || code[6:0] == SC_RIGHT_SHIFT) begin
            shift_down = 1'b1;
            return 1'b0;
        end
        if (code[6:0] == SC_CAPS_LOCK) begin
            caps_on = !caps_on;
            return 1'b0;
        end
        if (code >= KEY_COUNT)
            return 1'b0;
        ch = shift_down ? shift_keys[code[5:0]] : plain_keys[code[5:0]];
        if (ch == '0)
            return 1'b0;
        upper = caps_on ^ shift_down;
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z && upper)
            ch = ch - CH_CASE_STEP;
        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z && !upper)
            ch = ch + CH_CASE_STEP;
        if (ch == CH_NEWLINE) begin
            ev.kind    = EV_SUBMIT;
            ev.ch      = CH_NEWLINE;
            ev.pos     = 8'(char_count);
            char_count = 0;
            return 1'b1;
        end
        if (ch == CH_BACKSPACE) begin
            if (char_count == 0)
                return 1'b0;
            char_count = char_count - 1;
            ev.kind    = EV_ERASE;
            ev.ch      = CH_BACKSPACE;
            ev.pos     = 8'(char_count);
            return 1'b1;
        end
        if (ch < CH_FIRST_PRINT || ch > CH_LAST_PRINT)
            return 1'b0;
        if (char_count >= LEN_LIMIT)
            return 1'b0;
        ev.kind    = EV_APPEND;
        ev.ch      = ch;
        ev.pos     = 8'(char_count);
        char_count = char_count + 1;
        return 1'b1;
    endfunction

    task automatic log_mismatch(input string what, input t_line_event want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t %s: want kind %0d char %02h pos %0d, got kind %0d char %02h pos %0d",
                     $time, what, want.kind, want.ch, want.pos,
                     i_event_kind, i_char_code, i_line_position);
    endtask

    initial begin
        mismatch_count = 0;
        o_mismatches   = 0;
        o_awaiting     = 0;
    end

    always @(posedge i_clk) begin
        t_line_event want;
        t_line_event next_ev;
        if (!i_rst_n) begin
            shift_down  = 1'b0;
            caps_on     = 1'b0;
            prefix_seen = 1'b0;
            char_count  = 0;
            pending_events.delete();
        end else begin
            if (i_event_valid && i_event_ready) begin
                if (pending_events.size() == 0) begin
                    want.kind = EV_APPEND;
                    want.ch   = '0;
                    want.pos  = '0;
                    log_mismatch("event beat with nothing awaited", want);
                end else begin
                    want = pending_events.pop_front();
                    if (i_event_kind !== want.kind || i_char_code !== want.ch ||
                        i_line_position !== want.pos)
                        log_mismatch("event mismatch", want);
                end
            end
            if (i_scan_valid && i_scan_ready) begin
                if (decode_scancode(i_scan_code, next_ev))
                    pending_events.push_back(next_ev);
            end
        end
        o_mismatches = mismatch_count;
        o_awaiting   = pending_events.size();
    end

endmodule

/* tb/sv/tb_scancode_to_line_editor.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scancode to line editor testbench
// Feeds a short run of hand-picked scancodes, then random typed lines with
// shift, caps lock, prefixes, erases and noise, a few of them long enough to
// fill the line. The sender works in bursts and the receiver stalls, once for
// a long stretch. A checker beside the block predicts and compares events.
// ----------------------------------------------------------------------------
module tb_scancode_to_line_editor;
    import stle_pkg::*;

    localparam int LINE_CAPACITY = 300;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 12;

    localparam logic [7:0] KEY_ESCAPE    = 8'h01;
    localparam logic [7:0] KEY_DIGIT_ONE = 8'h02;
    localparam logic [7:0] KEY_BACKSPACE = 8'h0E;
    localparam logic [7:0] KEY_TAB       = 8'h0F;
    localparam logic [7:0] KEY_Q         = 8'h10;
    localparam logic [7:0] KEY_ENTER     = 8'h1C;
    localparam logic [7:0] KEY_CTRL      = 8'h1D;
    localparam logic [7:0] KEY_A         = 8'h1E;
    localparam logic [7:0] KEY_Z         = 8'h2C;
    localparam logic [7:0] KEY_STAR      = 8'h37;
    localparam logic [7:0] KEY_ALT       = 8'h38;
    localparam logic [7:0] KEY_SPACE     = 8'h39;
    localparam logic [7:0] KEY_F1        = 8'h3B;
    localparam logic [7:0] KEY_UNMAPPED  = 8'h00;
    localparam logic [7:0] KEY_TOP_MAKE  = 8'h7F;
    localparam logic [7:0] BREAK_BIT     = 8'h80;
    localparam logic [7:0] LSHIFT        = {1'b0, SC_LEFT_SHIFT};
    localparam logic [7:0] RSHIFT        = {1'b0, SC_RIGHT_SHIFT};
    localparam logic [7:0] CAPS          = {1'b0, SC_CAPS_LOCK};

    logic i_clk;
    logic i_rst_n;

    stle_scan_if  scan_bus ();
    stle_event_if event_bus ();

    int         mismatches;
    int         awaiting;
    logic [7:0] scan_codes [$];

    scancode_to_line_editor #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan_bus),
        .o_event (event_bus)
    );

    stle_line_checker #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) line_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_scan_valid    (scan_bus.valid),
        .i_scan_ready    (scan_bus.ready),
        .i_scan_code     (scan_bus.scan_code),
        .i_event_valid   (event_bus.valid),
        .i_event_ready   (event_bus.ready),
        .i_event_kind    (event_bus.event_kind),
        .i_char_code     (event_bus.char_code),
        .i_line_position (event_bus.line_position),
        .o_mismatches    (mismatches),
        .o_awaiting      (awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("tb_scancode_to_line_editor NOT OK");
        $finish;
    end

    function automatic logic [7:0] pick_print_key();
        logic [7:0] k;
        do
            k = 8'($urandom_range(2, 57));
        while (k == KEY_BACKSPACE || k == KEY_TAB || k == KEY_ENTER || k == KEY_CTRL ||
               k == LSHIFT || k == RSHIFT || k == KEY_ALT);
        return k;
    endfunction

    task automatic queue_key(input logic [7:0] code, input bit with_break);
        scan_codes.push_back(code);
        if (with_break)
            scan_codes.push_back(code | BREAK_BIT);
    endtask

    task automatic queue_line(input int keys, input bit dense);
        int r;
        repeat (keys) begin
            r = $urandom_range(0, 99);
            if (dense && r >= 66 && $urandom_range(0, 4) != 0)
                r = 0;
            if (r < 66)
                queue_key(pick_print_key(), 1'($urandom_range(0, 1)));
            else if (r < 74)
                queue_key(KEY_BACKSPACE, 1'($urandom_range(0, 1)));
            else if (r < 82)
                scan_codes.push_back(($urandom_range(0, 1) ? LSHIFT : RSHIFT) |
                                     ($urandom_range(0, 1) ? BREAK_BIT : 8'h00));
            else if (r < 86)
                queue_key(CAPS, 1'($urandom_range(0, 1)));
            else if (r < 90) begin
                scan_codes.push_back(SC_PREFIX);
                if ($urandom_range(0, 2) == 0)
                    scan_codes.push_back(SC_PREFIX);
                scan_codes.push_back(8'($urandom_range(0, 255)));
            end else if (r < 94) begin
                case ($urandom_range(0, 5))
                    0:       queue_key(KEY_ESCAPE, 1'b1);
                    1:       queue_key(KEY_TAB, 1'b1);
                    2:       queue_key(KEY_UNMAPPED, 1'b0);
                    3:       queue_key(KEY_CTRL, 1'b1);
                    4:       queue_key(KEY_ALT, 1'b1);
                    default: queue_key(8'($urandom_range(KEY_F1, KEY_TOP_MAKE)), 1'b0);
                endcase
            end else
                scan_codes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_scan_code(input logic [7:0] code);
        scan_bus.valid     <= 1'b1;
        scan_bus.scan_code <= code;
        do
            @(posedge i_clk);
        while (!scan_bus.ready);
    endtask

    initial begin
        int rx_cycles;
        int hold_left;
        int span;
        int mode;
        bit held;
        event_bus.ready <= 1'b0;
        rx_cycles = 0;
        hold_left = 0;
        span      = 0;
        mode      = 0;
        held      = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (hold_left > 0) begin
                event_bus.ready <= 1'b0;
                hold_left--;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 120);
                    if (!held && rx_cycles > 600) begin
                        held      = 1'b1;
                        hold_left = HOLD_CYCLES;
                    end
                end
                span--;
                case (mode)
                    0:       event_bus.ready <= 1'b1;
                    1:       event_bus.ready <= ($urandom_range(0, 3) != 0);
                    2:       event_bus.ready <= 1'($urandom_range(0, 1));
                    default: event_bus.ready <= (rx_cycles % 5 != 0);
                endcase
            end
        end
    end

    initial begin
        int burst_left;
        int gap;
        int directed_count;
        bit dense;
        i_rst_n            = 1'b0;
        scan_bus.valid     = 1'b0;
        scan_bus.scan_code = '0;

        scan_codes = '{KEY_BACKSPACE, KEY_A, KEY_A | BREAK_BIT,
                       LSHIFT, KEY_DIGIT_ONE, KEY_Q, LSHIFT | BREAK_BIT,
                       CAPS, CAPS | BREAK_BIT, KEY_Z, RSHIFT, KEY_Z, RSHIFT | BREAK_BIT, CAPS,
                       SC_PREFIX, KEY_ENTER, SC_PREFIX, SC_PREFIX, KEY_A,
                       KEY_UNMAPPED, KEY_CTRL, KEY_ALT, KEY_F1, KEY_TOP_MAKE,
                       KEY_TAB, KEY_ESCAPE, KEY_SPACE, KEY_STAR, KEY_BACKSPACE, 8'hFF,
                       KEY_ENTER};
        directed_count = scan_codes.size();
        while (scan_codes.size() < directed_count + RANDOM_ITEMS) begin
            dense = ($urandom_range(0, 9) == 0);
            queue_line(dense ? $urandom_range(280, 340) : $urandom_range(0, 30), dense);
            if ($urandom_range(0, 9) != 0)
                queue_key(KEY_ENTER, 1'($urandom_range(0, 1)));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(1, 40);
        foreach (scan_codes[i]) begin
            send_scan_code(scan_codes[i]);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    scan_bus.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
        scan_bus.valid <= 1'b0;

        @(negedge i_clk);
        while (awaiting != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0 && awaiting == 0)
            $display("tb_scancode_to_line_editor OK");
        else
            $display("tb_scancode_to_line_editor NOT OK");
        $finish;
    end

endmodule

/* scancode_to_line_editor.f */
rtl/stle_pkg.sv
rtl/stle_scan_if.sv
rtl/stle_event_if.sv
rtl/stle_keymap.sv
rtl/stle_editor.sv
rtl/scancode_to_line_editor.sv
tb/sv/stle_line_checker.sv
tb/sv/tb_scancode_to_line_editor.sv
